>>> src/spbg_pkg.sv
// Package for the span priority box generator: payload types, codes and the merge function.
`default_nettype none

package spbg_pkg;

    localparam int SPAN_SLOTS_DEFAULT        = 16;
    localparam int FIRST_ACTIVE_SLOT_DEFAULT = 3;

    localparam int CoordW = 8;
    localparam int ColorW = 4;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    localparam logic [1:0] FIELD_H_START = 2'd0;
    localparam logic [1:0] FIELD_V_START = 2'd1;
    localparam logic [1:0] FIELD_V_STOP  = 2'd2;
    localparam logic [1:0] FIELD_COLOR   = 2'd3;

    typedef struct packed {
        logic              kind;
        logic [3:0]        slot_index;
        logic [1:0]        field_select;
        logic [7:0]        write_value;
        logic [CoordW-1:0] pixel_x;
        logic [CoordW-1:0] pixel_y;
    } t_in;

    typedef struct packed {
        logic [ColorW-1:0] pen;
        logic [CoordW-1:0] screen_row;
    } t_out;

    // One node of the priority tree: the best covering slot seen in a subtree.
    typedef struct packed {
        logic              valid;
        logic [CoordW-1:0] h;
        logic [ColorW-1:0] color;
    } t_node;

    // The right subtree holds the higher slot numbers, so it also wins a tie.
    function automatic t_node spbg_merge(input t_node left, input t_node right);
        t_node res;
        if (right.valid && (!left.valid || (right.h >= left.h))) begin
            res = right;
        end else begin
            res = left;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> src/spbg_pick.sv
// Coverage test of every span slot and priority tree that selects the winning pen.
`default_nettype none

module spbg_pick #(
    parameter int SPAN_SLOTS        = spbg_pkg::SPAN_SLOTS_DEFAULT,
    parameter int FIRST_ACTIVE_SLOT = spbg_pkg::FIRST_ACTIVE_SLOT_DEFAULT
) (
    input  wire logic [SPAN_SLOTS-1:0][spbg_pkg::CoordW-1:0] i_h_start,
    input  wire logic [SPAN_SLOTS-1:0][spbg_pkg::CoordW-1:0] i_v_start,
    input  wire logic [SPAN_SLOTS-1:0][spbg_pkg::CoordW-1:0] i_v_stop,
    input  wire logic [SPAN_SLOTS-1:0][spbg_pkg::ColorW-1:0] i_color,
    input  wire logic [spbg_pkg::CoordW-1:0]                 i_x,
    input  wire logic [spbg_pkg::CoordW-1:0]                 i_y,
    output logic      [spbg_pkg::ColorW-1:0]                 o_pen
);

    localparam int Leaves = 2 ** $clog2(SPAN_SLOTS);

    spbg_pkg::t_node node [1:2*Leaves-1];

    always_comb begin
        // Leaves: slot s sits at Leaves + s; padding leaves never cover.
        for (int s = 0; s < Leaves; s++) begin
            node[Leaves+s] = '0;
            if ((s < SPAN_SLOTS) && (s >= FIRST_ACTIVE_SLOT)) begin
                node[Leaves+s].valid = (i_y >= i_v_start[s]) && (i_y <= i_v_stop[s]) &&
                                       (i_x >= i_h_start[s]);
                node[Leaves+s].h     = i_h_start[s];
                node[Leaves+s].color = i_color[s];
            end
        end
        for (int n = Leaves - 1; n >= 1; n--) begin
            node[n] = spbg_pkg::spbg_merge(node[2*n], node[2*n+1]);
        end
    end

    assign o_pen = node[1].valid ? node[1].color : '0;

endmodule

`default_nettype wire

>>> src/span_priority_box_generator.sv
// A pixel query passes the stage register, then the result register, from which it may leave.
// One item per cycle unless a pixel query waits on the result; writes and queries interleave freely.
// The span table and the coverage tree feed the result register in a single stage.
// A table write takes effect for every pixel query that follows it.
// Synchronous reset clears the span table to zero and empties both pipeline registers.
`default_nettype none

module span_priority_box_generator #(
    parameter int SPAN_SLOTS        = spbg_pkg::SPAN_SLOTS_DEFAULT,
    parameter int FIRST_ACTIVE_SLOT = spbg_pkg::FIRST_ACTIVE_SLOT_DEFAULT
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire spbg_pkg::t_in i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output spbg_pkg::t_out     o_out_data
);

    localparam int SlotW = $clog2(SPAN_SLOTS);

    logic [SPAN_SLOTS-1:0][spbg_pkg::CoordW-1:0] r_h_start;
    logic [SPAN_SLOTS-1:0][spbg_pkg::CoordW-1:0] r_v_start;
    logic [SPAN_SLOTS-1:0][spbg_pkg::CoordW-1:0] r_v_stop;
    logic [SPAN_SLOTS-1:0][spbg_pkg::ColorW-1:0] r_color;

    logic           r_s1_valid;
    spbg_pkg::t_in  r_s1;
    logic           r_out_valid;
    spbg_pkg::t_out r_out;

    logic                        s1_go;
    logic                        s1_is_pixel;
    logic                        wr_en;
    logic [SlotW-1:0]            wr_idx;
    logic [spbg_pkg::ColorW-1:0] pick_pen;

    // A table write leaves the stage at once; a pixel query waits for the result register.
    assign s1_is_pixel = (r_s1.kind == spbg_pkg::KIND_PIXEL);
    assign s1_go       = r_s1_valid && (!s1_is_pixel || !r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || s1_go;

    assign wr_en  = s1_go && !s1_is_pixel && (32'(r_s1.slot_index) < SPAN_SLOTS);
    assign wr_idx = SlotW'(r_s1.slot_index);

    spbg_pick #(
        .SPAN_SLOTS        (SPAN_SLOTS),
        .FIRST_ACTIVE_SLOT (FIRST_ACTIVE_SLOT)
    ) u_pick (
        .i_h_start (r_h_start),
        .i_v_start (r_v_start),
        .i_v_stop  (r_v_stop),
        .i_color   (r_color),
        .i_x       (r_s1.pixel_x),
        .i_y       (r_s1.pixel_y),
        .o_pen     (pick_pen)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_start <= '0;
            r_v_start <= '0;
            r_v_stop  <= '0;
            r_color   <= '0;
        end else if (wr_en) begin
            case (r_s1.field_select)
                spbg_pkg::FIELD_H_START: r_h_start[wr_idx] <= r_s1.write_value;
                spbg_pkg::FIELD_V_START: r_v_start[wr_idx] <= r_s1.write_value;
                spbg_pkg::FIELD_V_STOP:  r_v_stop[wr_idx]  <= r_s1.write_value;
                spbg_pkg::FIELD_COLOR:   r_color[wr_idx]   <= r_s1.write_value[3:0];
                default:                 r_color[wr_idx]   <= r_s1.write_value[3:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
        if (o_in_ready) begin
            r_s1 <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && s1_is_pixel) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (s1_go && s1_is_pixel) begin
            r_out.pen        <= pick_pen;
            r_out.screen_row <= ~r_s1.pixel_y;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The input side stalls only behind a pixel query that cannot leave.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_valid && s1_is_pixel && r_out_valid && !i_out_ready))
        else $error("input stalled without a blocked pixel query");

    // A query that leaves the stage always produces a result.
    a_query_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && s1_is_pixel) |=> r_out_valid)
        else $error("pixel query lost between stage and result register");

    // The result row is the flipped row of the query that produced it.
    a_row_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && s1_is_pixel) |=> (r_out.screen_row == ~$past(r_s1.pixel_y)))
        else $error("screen row does not match the flipped pixel row");

    // A table write never loads the result register.
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && !s1_is_pixel && r_out_valid && i_out_ready) |=> !r_out_valid)
        else $error("table write produced a result");

endmodule

`default_nettype wire

>>> tb/sv/span_box_checker.sv
// Checker for the span priority box generator: span table shadow, pen prediction and comparison.
module span_box_checker
    import spbg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [CoordW-1:0] h_start [SPAN_SLOTS_DEFAULT];
    logic [CoordW-1:0] v_start [SPAN_SLOTS_DEFAULT];
    logic [CoordW-1:0] v_stop  [SPAN_SLOTS_DEFAULT];
    logic [ColorW-1:0] color   [SPAN_SLOTS_DEFAULT];

    t_out pending_pixels[$];

    // The covering span with the largest start wins; a later slot takes a tie.
    function automatic t_out shade_pixel(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y);
        t_out              res;
        logic              hit;
        logic [CoordW-1:0] best_h;
        int                s;
        hit     = 1'b0;
        best_h  = '0;
        res.pen = '0;
        for (s = FIRST_ACTIVE_SLOT_DEFAULT; s < SPAN_SLOTS_DEFAULT; s++) begin
            if (y >= v_start[s] && y <= v_stop[s] && x >= h_start[s] &&
                (!hit || h_start[s] >= best_h)) begin
                hit     = 1'b1;
                best_h  = h_start[s];
                res.pen = color[s];
            end
        end
        res.screen_row = 8'hFF - y;
        return res;
    endfunction

    // Inputs are sampled before the edge updates, so the result side is
    // checked first and the new transfer is recorded after it.
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            for (int s = 0; s < SPAN_SLOTS_DEFAULT; s++) begin
                h_start[s] = '0;
                v_start[s] = '0;
                v_stop[s]  = '0;
                color[s]   = '0;
            end
            pending_pixels.delete();
            o_fail_count = 0;
            o_pending    = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_pixels.size() == 0) begin
                    $error("result transfer with no pixel query outstanding: pen %0d, row %0d",
                           i_out_data.pen, i_out_data.screen_row);
                    o_fail_count++;
                end else begin
                    want = pending_pixels.pop_front();
                    if (i_out_data.pen !== want.pen) begin
                        $error("pen: expected %0d, actual %0d", want.pen, i_out_data.pen);
                        o_fail_count++;
                    end
                    if (i_out_data.screen_row !== want.screen_row) begin
                        $error("screen_row: expected %0d, actual %0d",
                               want.screen_row, i_out_data.screen_row);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.kind == KIND_WRITE) begin
                    case (i_in_data.field_select)
                        FIELD_H_START: h_start[i_in_data.slot_index] = i_in_data.write_value;
                        FIELD_V_START: v_start[i_in_data.slot_index] = i_in_data.write_value;
                        FIELD_V_STOP:  v_stop[i_in_data.slot_index]  = i_in_data.write_value;
                        FIELD_COLOR: begin
                            color[i_in_data.slot_index] = i_in_data.write_value[ColorW-1:0];
                        end
                        default: ;
                    endcase
                end else begin
                    pending_pixels.push_back(shade_pixel(i_in_data.pixel_x, i_in_data.pixel_y));
                end
            end
            o_pending = pending_pixels.size();
        end
    end

endmodule

>>> tb/sv/span_priority_box_generator_test.sv
// Top of the span priority box generator testbench: clock, reset, stimulus and verdict.
module span_priority_box_generator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import spbg_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 234;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic in_valid;
    logic in_ready;
    t_in  in_data;
    logic out_valid;
    logic out_ready;
    t_out out_data;

    int          send_idle_pct;
    int          recv_idle_pct;
    int          fail_count;
    int          pending;
    int unsigned cycle_count = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    span_priority_box_generator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    span_box_checker CHECK (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL span_priority_box_generator");
            $finish;
        end
    end

    // The pixel fields of a table write carry noise that the block must ignore.
    function automatic t_in table_write(input logic [3:0] slot, input logic [1:0] field,
                                        input logic [7:0] value);
        t_in item;
        item.kind         = KIND_WRITE;
        item.slot_index   = slot;
        item.field_select = field;
        item.write_value  = value;
        item.pixel_x      = CoordW'($urandom);
        item.pixel_y      = CoordW'($urandom);
        return item;
    endfunction

    function automatic t_in pixel_query(input logic [7:0] x, input logic [7:0] y);
        t_in item;
        item.kind         = KIND_PIXEL;
        item.slot_index   = 4'($urandom);
        item.field_select = 2'($urandom);
        item.write_value  = 8'($urandom);
        item.pixel_x      = x;
        item.pixel_y      = y;
        return item;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send(input t_in item);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge i_clk); while (!in_ready);
        @(negedge i_clk);
    endtask

    // Spans are biased towards tall, overlapping shapes with shared starts so
    // that queries land on several covering slots and on ties.
    task automatic send_random;
        logic [1:0] field;
        logic [7:0] value;
        if ($urandom_range(99) < 35) begin
            field = 2'($urandom);
            value = 8'($urandom);
            case (field)
                FIELD_H_START: if ($urandom_range(3) == 0) value = 8'($urandom_range(3)) << 6;
                FIELD_V_START: if ($urandom_range(1) == 1) value = 8'($urandom_range(127));
                FIELD_V_STOP:  if ($urandom_range(1) == 1) value = 8'($urandom_range(255, 128));
                default: ;
            endcase
            send(table_write(4'($urandom), field, value));
        end else begin
            send(pixel_query(8'($urandom), 8'($urandom)));
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_ready     = 1'b0;
        send_idle_pct = 14;
        recv_idle_pct = 59;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The cleared table covers only row 0 and only with pen 0.
        send(pixel_query(8'hFF, 8'hFF));
        send(pixel_query(8'h00, 8'h00));
        // Slot 0 lies below the first active slot, so this full-screen span must never show.
        send(table_write(4'd0, FIELD_H_START, 8'h00));
        send(table_write(4'd0, FIELD_V_STOP, 8'hFF));
        send(table_write(4'd0, FIELD_COLOR, 8'h09));
        send(table_write(4'd3, FIELD_H_START, 8'h10));
        send(table_write(4'd3, FIELD_V_START, 8'h10));
        send(table_write(4'd3, FIELD_V_STOP, 8'hF0));
        send(table_write(4'd3, FIELD_COLOR, 8'hFF));
        // Slot 15 shares the start of slot 3 and must win the tie.
        send(table_write(4'd15, FIELD_H_START, 8'h10));
        send(table_write(4'd15, FIELD_V_STOP, 8'hFF));
        send(table_write(4'd15, FIELD_COLOR, 8'hA5));
        // Slot 7 has its start above its stop, so it is empty.
        send(table_write(4'd7, FIELD_V_START, 8'h80));
        send(table_write(4'd7, FIELD_V_STOP, 8'h40));
        send(table_write(4'd7, FIELD_COLOR, 8'h03));
        send(pixel_query(8'h10, 8'h20));
        send(pixel_query(8'h0F, 8'h20));
        send(pixel_query(8'hFF, 8'h00));
        send(pixel_query(8'h00, 8'hFF));
        send(pixel_query(8'h60, 8'h60));
        send(table_write(4'd3, FIELD_H_START, 8'hFF));
        send(pixel_query(8'hFF, 8'h80));

        repeat (PHASE_ITEMS) send_random();
        send_idle_pct = 59;
        recv_idle_pct = 14;
        repeat (PHASE_ITEMS) send_random();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (PHASE_ITEMS) send_random();
        in_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("PASS span_priority_box_generator");
        end else begin
            $display("FAIL span_priority_box_generator");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/spbg_pkg.sv
src/spbg_pick.sv
src/span_priority_box_generator.sv
tb/sv/span_box_checker.sv
tb/sv/span_priority_box_generator_test.sv
